>>> rtl/swm_pkg.sv
// shared types and constants for the sliding window median filter
// no dependencies; imported by every module of the block
package swm_pkg;

    localparam int CFG_W       = 7;
    localparam int SAMPLE_W    = 32;
    localparam int RESULT_W    = SAMPLE_W + 1;
    localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

    // what the cell row does in a cycle
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_PUSH,
        OP_PURGE
    } t_op;

    // what a cell shows its neighbours, from its own registers and the sample and window inputs
    typedef struct packed {
        logic                       valid;
        logic                       gt;
        logic                       drop;
        logic signed [SAMPLE_W-1:0] value;
    } t_cell_tap;

endpackage

>>> rtl/sliding_window_median.sv
// running median over the last window_len samples, built as a row of sorted cells
// result is twice the median (one fractional bit), exact
// each sample is registered in the cell row, and its result then in the result queue that drives o_m_tvalid
// throughput: one sample per cycle while the result queue has room; after window_len
//   is lowered mid-sequence, the next sample waits while the cell row drops surplus entries
// reset: synchronous, active low; empties the window and the result queue, window_len = 1
module sliding_window_median
    import swm_pkg::*;
#(
    parameter int MAX_WINDOW = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [SAMPLE_W-1:0]    i_s_tdata,   // [31:0] sample
    input  logic                   i_s_tlast,   // last_sample
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // [32:0] median_doubled, rest zero
    output logic                   o_m_tlast,   // end_of_sequence
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_W-1:0]       i_cfg_data   // window_len
);

    localparam int AW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW   = $clog2(MAX_WINDOW + 1);
    localparam int CMPW = (CW > CFG_W) ? CW : CFG_W;
    localparam int QW   = RESULT_W + 1;

    logic [CW-1:0] r_len;
    logic [CW-1:0] n_len;
    logic [CW-1:0] r_fill;
    logic [CW-1:0] n_fill;
    logic          r_flush;
    logic          n_flush;
    logic          r_s1_valid;
    logic          n_s1_valid;
    logic          r_s1_last;
    logic          n_s1_last;

    t_op           op;
    logic          s_xfer;
    logic          multi;
    logic          drop_any;
    logic [CW-1:0] fill_pushed;
    logic [CMPW-1:0] cfg_ext;
    logic [AW-1:0] len_m1;
    logic [AW-1:0] hi_idx;
    logic [AW-1:0] lo_idx;
    logic signed [RESULT_W-1:0] median_sum;
    logic [2:0]    q_level;
    logic [QW-1:0] q_data;

    t_cell_tap                  w_tap   [MAX_WINDOW+2];
    logic [AW-1:0]              w_age   [MAX_WINDOW+2];
    logic                       w_del   [MAX_WINDOW+1];
    logic                       w_multi [MAX_WINDOW+1];
    logic                       w_valid_vec [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]      valid_bits;
    logic signed [SAMPLE_W-1:0] w_val   [MAX_WINDOW];

    // row ends: a kept entry on the left, an empty slot on the right
    assign w_tap[0]            = '{valid: 1'b1, gt: 1'b0, drop: 1'b0, value: '0};
    assign w_age[0]            = '0;
    assign w_tap[MAX_WINDOW+1] = '{valid: 1'b0, gt: 1'b0, drop: 1'b0, value: '0};
    assign w_age[MAX_WINDOW+1] = '0;
    assign w_del[0]            = 1'b0;
    assign w_multi[0]          = 1'b0;

    assign len_m1 = AW'(r_len - CW'(1));

    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        swm_cell #(
            .AW (AW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_op         (op),
            .i_sample     (i_s_tdata),
            .i_len_m1     (len_m1),
            .i_flush      (r_flush),
            .i_left       (w_tap[g]),
            .i_left_age   (w_age[g]),
            .i_right      (w_tap[g+2]),
            .i_right_age  (w_age[g+2]),
            .i_del_left   (w_del[g]),
            .i_multi_left (w_multi[g]),
            .o_tap        (w_tap[g+1]),
            .o_age        (w_age[g+1]),
            .o_del        (w_del[g+1]),
            .o_multi      (w_multi[g+1])
        );
        assign w_val[g]       = w_tap[g+1].value;
        assign w_valid_vec[g] = w_tap[g+1].valid;
        assign valid_bits[g]  = w_valid_vec[g];
    end

    assign drop_any = w_del[MAX_WINDOW];
    assign multi    = w_multi[MAX_WINDOW];

    // room for the item in the median stage plus the queue
    assign o_s_tready  = ~multi & ((q_level + 3'(r_s1_valid)) < 3'd4);
    assign s_xfer      = i_s_tvalid & o_s_tready;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (multi) begin
            op = OP_PURGE;
        end else if (s_xfer) begin
            op = OP_PUSH;
        end else begin
            op = OP_HOLD;
        end
    end

    assign cfg_ext     = CMPW'(i_cfg_data);
    assign fill_pushed = (r_flush ? CW'(0) : r_fill) - CW'(drop_any) + CW'(1);

    always_comb begin
        n_len      = r_len;
        n_fill     = r_fill;
        n_flush    = r_flush;
        n_s1_valid = 1'b0;
        n_s1_last  = r_s1_last;
        if (i_cfg_valid) begin
            if (cfg_ext == '0) begin
                n_len = CW'(1);
            end else if (cfg_ext > CMPW'(MAX_WINDOW)) begin
                n_len = CW'(MAX_WINDOW);
            end else begin
                n_len = CW'(cfg_ext);
            end
        end
        case (op)
            OP_PUSH: begin
                n_s1_valid = fill_pushed == r_len;
                n_s1_last  = i_s_tlast;
                n_flush    = i_s_tlast;
                n_fill     = i_s_tlast ? CW'(0) : fill_pushed;
            end
            OP_PURGE: begin
                n_fill = r_fill - CW'(1);
            end
            default: begin
                n_fill = r_fill;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= CW'(1);
            r_fill     <= '0;
            r_flush    <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            r_len      <= n_len;
            r_fill     <= n_fill;
            r_flush    <= n_flush;
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_last <= n_s1_last;
    end

    // middle pair, read from the row the cycle after the insertion
    assign hi_idx     = AW'(r_len >> 1);
    assign lo_idx     = r_len[0] ? hi_idx : hi_idx - AW'(1);
    assign median_sum = {w_val[lo_idx][SAMPLE_W-1], w_val[lo_idx]}
                      + {w_val[hi_idx][SAMPLE_W-1], w_val[hi_idx]};

    swm_out_fifo #(
        .WIDTH (QW)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_valid),
        .i_data  ({r_s1_last, median_sum}),
        .i_pop   (i_m_tready),
        .o_valid (o_m_tvalid),
        .o_data  (q_data),
        .o_level (q_level)
    );

    assign o_m_tdata = {{(OUT_TDATA_W - RESULT_W){1'b0}}, q_data[RESULT_W-1:0]};
    assign o_m_tlast = q_data[QW-1];

    a_fill_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_flush |-> ($countones(valid_bits) == int'(r_fill)))
        else $error("fill count disagrees with occupied cells");

    a_purge_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (op == OP_PURGE) |=> (r_fill == $past(r_fill) - CW'(1)))
        else $error("purge cycle did not remove one entry");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(MAX_WINDOW))
        else $error("fill count beyond window capacity");

    a_result_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |=> (q_level != 3'd0))
        else $error("median result not queued");

endmodule

>>> rtl/swm_cell.sv
// one cell of the sorted window: holds a sample, its age and a valid bit
// depends on swm_pkg; instantiated in a row by sliding_window_median
module swm_cell
    import swm_pkg::*;
#(
    parameter int AW = 6
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_op                        i_op,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic [AW-1:0]              i_len_m1,
    input  logic                       i_flush,
    input  t_cell_tap                  i_left,
    input  logic [AW-1:0]              i_left_age,
    input  t_cell_tap                  i_right,
    input  logic [AW-1:0]              i_right_age,
    input  logic                       i_del_left,
    input  logic                       i_multi_left,
    output t_cell_tap                  o_tap,
    output logic [AW-1:0]              o_age,
    output logic                       o_del,
    output logic                       o_multi
);

    logic                       r_valid;
    logic signed [SAMPLE_W-1:0] r_val;
    logic [AW-1:0]              r_age;
    logic                       n_valid;
    logic signed [SAMPLE_W-1:0] n_val;
    logic [AW-1:0]              n_age;

    logic                       eff_valid;
    logic                       del_self;
    t_cell_tap                  post_self;
    logic [AW-1:0]              post_self_age;
    t_cell_tap                  post_left;
    logic [AW-1:0]              post_left_age;
    logic                       keep_self;
    logic                       keep_left;

    assign eff_valid = r_valid & ~i_flush;

    assign o_tap.valid = eff_valid;
    assign o_tap.gt    = r_val > i_sample;
    assign o_tap.drop  = eff_valid & (r_age >= i_len_m1);
    assign o_tap.value = r_val;
    assign o_age       = r_age;

    // first drop found so far, and a second one behind it
    assign del_self = i_del_left | o_tap.drop;
    assign o_del    = del_self;
    assign o_multi  = i_multi_left | (i_del_left & o_tap.drop);

    // contents after removing the first dropped entry
    assign post_self     = del_self ? i_right : o_tap;
    assign post_self_age = del_self ? i_right_age : r_age;
    assign post_left     = i_del_left ? o_tap : i_left;
    assign post_left_age = i_del_left ? r_age : i_left_age;

    assign keep_self = post_self.valid & ~post_self.gt;
    assign keep_left = post_left.valid & ~post_left.gt;

    always_comb begin
        n_valid = r_valid;
        n_val   = r_val;
        n_age   = r_age;
        case (i_op)
            OP_PUSH: begin
                if (keep_self) begin
                    n_valid = 1'b1;
                    n_val   = post_self.value;
                    n_age   = post_self_age + AW'(1);
                end else if (keep_left) begin
                    n_valid = 1'b1;
                    n_val   = i_sample;
                    n_age   = '0;
                end else begin
                    n_valid = post_left.valid;
                    n_val   = post_left.value;
                    n_age   = post_left_age + AW'(1);
                end
            end
            OP_PURGE: begin
                n_valid = post_self.valid;
                n_val   = post_self.value;
                n_age   = post_self_age;
            end
            default: begin
                n_valid = r_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_age <= n_age;
    end

endmodule

>>> rtl/swm_out_fifo.sv
// four-entry result queue between the median adder and the output stream
// depends on swm_pkg; instantiated by sliding_window_median
module swm_out_fifo
    import swm_pkg::*;
#(
    parameter int WIDTH = RESULT_W + 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    output logic [2:0]       o_level
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [2:0]       r_level;
    logic             pop_ok;

    assign pop_ok  = i_pop & (r_level != 3'd0);
    assign o_valid = r_level != 3'd0;
    assign o_data  = r_mem[r_rd_ptr];
    assign o_level = r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            r_level <= r_level + 3'(i_push) - 3'(pop_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_level != 3'(DEPTH)))
        else $error("result queue written while full");

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= 3'(DEPTH))
        else $error("result queue level out of range");

endmodule
